FILE: sv/nnfs_pkg.sv
package nnfs_pkg;

   // field and register widths
   localparam int CFG_W   = 9;
   localparam int CSR_I_W = 3;
   localparam int ADDR_W  = 14;
   localparam int PIX_W   = 16;
   localparam int POS_W   = 8;
   // dividend width: position (8 bits) times a side of at most 256
   localparam int NUM_W   = 16;
   localparam int CNT_W   = $clog2(NUM_W);

   // register indexes
   localparam logic [CSR_I_W-1:0] CSR_BUFFER_WIDTH   = 3'd0;
   localparam logic [CSR_I_W-1:0] CSR_BUFFER_HEIGHT  = 3'd1;
   localparam logic [CSR_I_W-1:0] CSR_SCREEN_WIDTH   = 3'd2;
   localparam logic [CSR_I_W-1:0] CSR_SCREEN_HEIGHT  = 3'd3;
   localparam logic [CSR_I_W-1:0] CSR_ROWS_PER_BURST = 3'd4;

   // register reset values
   localparam logic [CFG_W-1:0] RST_BUFFER_WIDTH   = 9'd128;
   localparam logic [CFG_W-1:0] RST_BUFFER_HEIGHT  = 9'd128;
   localparam logic [CFG_W-1:0] RST_SCREEN_WIDTH   = 9'd240;
   localparam logic [CFG_W-1:0] RST_SCREEN_HEIGHT  = 9'd240;
   localparam logic [CFG_W-1:0] RST_ROWS_PER_BURST = 9'd10;

   // source side limit
   localparam logic [CFG_W-1:0] SIDE_MAX = 9'd256;

   // operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EMIT  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CLAMP,
      ST_LINEAR,
      ST_FETCH,
      ST_DELIVER
   } nnfs_state_type;

   typedef struct packed {
      logic write;      // store the incoming pixel
      logic start;      // latch flags, launch both scale divisions
      logic clamp;      // register clamped source column and row
      logic wrap;       // register the wrapped buffer address
      logic fetch;      // read the back buffer
      logic load;       // fill output register and advance raster
   } nnfs_cmd_type;

   typedef struct packed {
      logic step_done;  // both dividers finish this cycle
   } nnfs_status_type;

   // zero acts as one, saturate at 256
   function automatic logic [CFG_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] r;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (v > SIDE_MAX) begin
         r = SIDE_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

FILE: sv/nnfs_div.sv
module nnfs_div
   import nnfs_pkg::*;
#(
   parameter int DEN_W = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial    = {rem_ff, quo_ff[NUM_W-1]};
      diff     = trial - {1'b0, den_ff};
      fits     = trial >= {1'b0, den_ff};
      done     = busy_ff && (count_ff == CNT_W'(NUM_W - 1));
      busy_in  = busy_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = numer;
         rem_in   = '0;
         den_in   = denom;
      end else if (busy_ff) begin
         count_in = count_ff + CNT_W'(1);
         quo_in   = {quo_ff[NUM_W-2:0], fits};
         rem_in   = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;

endmodule

FILE: sv/nnfs_ctrl.sv
module nnfs_ctrl
   import nnfs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_operation,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  nnfs_status_type status,
   output nnfs_cmd_type    cmd
);

   nnfs_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_operation == OP_EMIT) begin
                  cmd.start = 1'b1;
                  state_in  = ST_DIVIDE;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_DIVIDE: begin
            if (status.step_done) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = ST_LINEAR;
         end
         ST_LINEAR: begin
            cmd.wrap = 1'b1;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_DELIVER;
         end
         ST_DELIVER: begin
            // wait for a free output register
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/nnfs_datapath.sv
module nnfs_datapath
   import nnfs_pkg::*;
#(
   parameter int BUFFER_DEPTH    = 16384,
   parameter int MAX_SCREEN_SIDE = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [CSR_I_W-1:0] csr_index,
   input  logic [CFG_W-1:0]   csr_write_data,
   input  logic [ADDR_W-1:0]  req_pixel_address,
   input  logic [PIX_W-1:0]   req_pixel_value,
   input  nnfs_cmd_type       cmd,
   output nnfs_status_type    status,
   output logic [PIX_W-1:0]   rsp_pixel,
   output logic               rsp_burst_end,
   output logic               rsp_frame_end
);

   localparam int SIDE_W  = ($clog2(MAX_SCREEN_SIDE + 1) > CFG_W) ?
                            $clog2(MAX_SCREEN_SIDE + 1) : CFG_W;
   localparam int DEPTH_W = $clog2(BUFFER_DEPTH + 1);
   localparam int DEN_W   = SIDE_W;
   localparam int AW      = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int CMP_W   = (ADDR_W > DEPTH_W) ? ADDR_W : DEPTH_W;
   localparam int PROD_W  = POS_W + CFG_W;
   // highest shift of the depth that still fits under the linear address range
   localparam int WRAP_W   = NUM_W + 1;
   localparam int WRAP_TOP = NUM_W - DEPTH_W;

   localparam logic [SIDE_W-1:0] SCREEN_MAX = SIDE_W'(MAX_SCREEN_SIDE);
   localparam logic [CMP_W-1:0]  DEPTH_CMP  = CMP_W'(BUFFER_DEPTH);
   localparam logic [WRAP_W-1:0] DEPTH_WRAP = WRAP_W'(BUFFER_DEPTH);

   // configuration registers
   logic [CFG_W-1:0] buffer_width_ff, buffer_height_ff;
   logic [CFG_W-1:0] screen_width_ff, screen_height_ff, rows_per_burst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_width_ff   <= RST_BUFFER_WIDTH;
         buffer_height_ff  <= RST_BUFFER_HEIGHT;
         screen_width_ff   <= RST_SCREEN_WIDTH;
         screen_height_ff  <= RST_SCREEN_HEIGHT;
         rows_per_burst_ff <= RST_ROWS_PER_BURST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BUFFER_WIDTH:   buffer_width_ff   <= csr_write_data;
            CSR_BUFFER_HEIGHT:  buffer_height_ff  <= csr_write_data;
            CSR_SCREEN_WIDTH:   screen_width_ff   <= csr_write_data;
            CSR_SCREEN_HEIGHT:  screen_height_ff  <= csr_write_data;
            CSR_ROWS_PER_BURST: rows_per_burst_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // effective sides
   logic [CFG_W-1:0]  bw, bh, rpb;
   logic [SIDE_W-1:0] sw, sh, sw_raw, sh_raw;

   always_comb begin
      bw     = clamp_side(buffer_width_ff);
      bh     = clamp_side(buffer_height_ff);
      rpb    = clamp_side(rows_per_burst_ff);
      sw_raw = SIDE_W'(screen_width_ff);
      sh_raw = SIDE_W'(screen_height_ff);
      if (sw_raw == '0) begin
         sw = SIDE_W'(1);
      end else if (sw_raw > SCREEN_MAX) begin
         sw = SCREEN_MAX;
      end else begin
         sw = sw_raw;
      end
      if (sh_raw == '0) begin
         sh = SIDE_W'(1);
      end else if (sh_raw > SCREEN_MAX) begin
         sh = SCREEN_MAX;
      end else begin
         sh = sh_raw;
      end
   end

   // raster position and end flags
   logic [POS_W-1:0] col_ff, col_in, row_ff, row_in, rib_ff, rib_in;
   logic             last_col_ff, burst_ff, frame_ff;
   logic             last_col, last_row, burst_now;

   always_comb begin
      last_col  = (SIDE_W'(col_ff) + SIDE_W'(1)) >= sw;
      last_row  = (SIDE_W'(row_ff) + SIDE_W'(1)) >= sh;
      burst_now = last_col &&
                  (last_row || ((CFG_W'(rib_ff) + CFG_W'(1)) >= rpb));
      col_in = col_ff;
      row_in = row_ff;
      rib_in = rib_ff;
      if (cmd.load) begin
         if (frame_ff) begin
            col_in = '0;
            row_in = '0;
            rib_in = '0;
         end else if (last_col_ff) begin
            col_in = '0;
            row_in = row_ff + POS_W'(1);
            rib_in = burst_ff ? '0 : (rib_ff + POS_W'(1));
         end else begin
            col_in = col_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         rib_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         rib_ff <= rib_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         last_col_ff <= last_col;
         burst_ff    <= burst_now;
         frame_ff    <= last_col && last_row;
      end
   end

   // scale products
   logic [PROD_W-1:0] prod_x, prod_y, lin;
   logic [POS_W-1:0]  sx_ff, sy_ff;
   logic [NUM_W-1:0]  quo_a, quo_b;
   logic              done_a, done_b;

   assign prod_x = PROD_W'(col_ff) * PROD_W'(bw);
   assign prod_y = PROD_W'(row_ff) * PROD_W'(bh);
   assign lin    = PROD_W'(sy_ff) * PROD_W'(bw) + PROD_W'(sx_ff);

   // unit a: column scale
   nnfs_div #(.DEN_W(DEN_W)) u_div_a (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start),
      .numer    (prod_x[NUM_W-1:0]),
      .denom    (DEN_W'(sw)),
      .done     (done_a),
      .quotient (quo_a)
   );

   // unit b: row scale
   nnfs_div #(.DEN_W(DEN_W)) u_div_b (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start),
      .numer    (prod_y[NUM_W-1:0]),
      .denom    (DEN_W'(sh)),
      .done     (done_b),
      .quotient (quo_b)
   );

   // both units run the same length
   assign status.step_done = done_a && done_b;

   always_ff @(posedge clock) begin
      if (cmd.clamp) begin
         sx_ff <= (quo_a >= NUM_W'(bw)) ? POS_W'(bw - CFG_W'(1)) : quo_a[POS_W-1:0];
         sy_ff <= (quo_b >= NUM_W'(bh)) ? POS_W'(bh - CFG_W'(1)) : quo_b[POS_W-1:0];
      end
   end

   // address wrap: subtract shifted copies of the depth, largest first
   logic [WRAP_W-1:0] wrap_acc;
   logic [AW-1:0]     rd_addr_ff;

   always_comb begin
      wrap_acc = WRAP_W'(lin[NUM_W-1:0]);
      for (int s = WRAP_TOP; s >= 0; s--) begin
         if (wrap_acc >= (DEPTH_WRAP << s)) begin
            wrap_acc = wrap_acc - (DEPTH_WRAP << s);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wrap) begin
         rd_addr_ff <= wrap_acc[AW-1:0];
      end
   end

   // back buffer
   logic [PIX_W-1:0] mem [BUFFER_DEPTH];
   logic [PIX_W-1:0] rd_data_ff;
   logic [CMP_W-1:0] wr_addr;

   assign wr_addr = CMP_W'(req_pixel_address);

   always_ff @(posedge clock) begin
      if (cmd.write && (wr_addr < DEPTH_CMP)) begin
         mem[wr_addr[AW-1:0]] <= req_pixel_value;
      end
      if (cmd.fetch) begin
         rd_data_ff <= mem[rd_addr_ff];
      end
   end

   // output register
   logic [PIX_W-1:0] out_pixel_ff;
   logic             out_burst_ff, out_frame_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_pixel_ff <= rd_data_ff;
         out_burst_ff <= burst_ff;
         out_frame_ff <= frame_ff;
      end
   end

   assign rsp_pixel     = out_pixel_ff;
   assign rsp_burst_end = out_burst_ff;
   assign rsp_frame_end = out_frame_ff;

endmodule

FILE: sv/nearest_neighbor_frame_scaler_top.sv
// channel | ports                               | direction | beat accepted when
// req     | req_valid/req_stall, req_* fields   | in        | req_valid && !req_stall
// rsp     | rsp_valid/rsp_stall, rsp_* fields   | out       | rsp_valid && !rsp_stall
// csr     | csr_write_enable, index, write_data | in        | csr_write_enable
//
// a write beat leaves the input free at once; an emit beat holds the input through
// two 16-step restoring divisions (column and row scale) running side by side
// plus clamp, address wrap by compare and subtract, buffer read and output load
// the output register lets a new beat in while the last pixel waits on rsp_stall
// reset is synchronous, clears raster position, registers and handshake state;
// the back buffer is not cleared and no clearing pass runs
module nearest_neighbor_frame_scaler_top
   import nnfs_pkg::*;
#(
   parameter int BUFFER_DEPTH    = 16384,
   parameter int MAX_SCREEN_SIDE = 256
) (
   input  logic               clock,
   input  logic               reset,
   // configuration writes
   input  logic               csr_write_enable,
   input  logic [CSR_I_W-1:0] csr_index,
   input  logic [CFG_W-1:0]   csr_write_data,
   // request beats
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [ADDR_W-1:0]  req_pixel_address,
   input  logic [PIX_W-1:0]   req_pixel_value,
   // response beats
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [PIX_W-1:0]   rsp_pixel,
   output logic               rsp_burst_end,
   output logic               rsp_frame_end
);

   nnfs_cmd_type    cmd;
   nnfs_status_type status;

   // sequencer: accepts beats, steps the datapath, owns rsp_valid
   nnfs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // registers, raster counters, dividers, back buffer, output payload
   nnfs_datapath #(
      .BUFFER_DEPTH    (BUFFER_DEPTH),
      .MAX_SCREEN_SIDE (MAX_SCREEN_SIDE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_pixel_address (req_pixel_address),
      .req_pixel_value   (req_pixel_value),
      .cmd               (cmd),
      .status            (status),
      .rsp_pixel         (rsp_pixel),
      .rsp_burst_end     (rsp_burst_end),
      .rsp_frame_end     (rsp_frame_end)
   );

endmodule

FILE: sv/nnfs_checker.sv
module nnfs_checker
   import nnfs_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_operation,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_burst_end,
   input logic rsp_frame_end
);

   // a pending beat is not dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // a frame always closes its burst
   a_frame_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_burst_end)
      else $error("frame end without burst end");

   // the input stalls right after an emit beat is taken
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_operation == OP_EMIT) |=> req_stall)
      else $error("input taken during an emit");

   // nothing leaves right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind nearest_neighbor_frame_scaler_top nnfs_checker u_nnfs_checker (.*);

FILE: tb/scaled_pixel_checker.sv
module scaled_pixel_checker
   import nnfs_pkg::*;
#(
   parameter int BUFFER_DEPTH    = 16384,
   parameter int MAX_SCREEN_SIDE = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [CSR_I_W-1:0] csr_index,
   input  logic [CFG_W-1:0]   csr_write_data,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_operation,
   input  logic [ADDR_W-1:0]  req_pixel_address,
   input  logic [PIX_W-1:0]   req_pixel_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [PIX_W-1:0]   rsp_pixel,
   input  logic               rsp_burst_end,
   input  logic               rsp_frame_end,
   output int                 outstanding,
   output int                 mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [PIX_W-1:0] pixel;
      logic             burst_end;
      logic             frame_end;
   } screen_beat_type;

   logic [PIX_W-1:0] frame_store [BUFFER_DEPTH];
   logic [CFG_W-1:0] cfg_reg [0:CSR_ROWS_PER_BURST];
   int unsigned      raster_col;
   int unsigned      raster_row;
   int unsigned      burst_row;
   screen_beat_type  pending_pixels [$];
   int               errors = 0;

   // zero acts as one, anything above the ceiling saturates
   function automatic int unsigned usable_side(input logic [CFG_W-1:0] v,
                                               input int unsigned ceiling);
      int unsigned s;
      s = v;
      if (s == 0) begin
         s = 1;
      end else if (s > ceiling) begin
         s = ceiling;
      end
      return s;
   endfunction

   // next screen pixel in raster order, advances the raster position
   function automatic screen_beat_type predict_screen_pixel();
      int unsigned     bw, bh, sw, sh, rpb, sx, sy, addr;
      logic            last_col, last_row;
      screen_beat_type b;
      bw  = usable_side(cfg_reg[CSR_BUFFER_WIDTH], SIDE_MAX);
      bh  = usable_side(cfg_reg[CSR_BUFFER_HEIGHT], SIDE_MAX);
      sw  = usable_side(cfg_reg[CSR_SCREEN_WIDTH], MAX_SCREEN_SIDE);
      sh  = usable_side(cfg_reg[CSR_SCREEN_HEIGHT], MAX_SCREEN_SIDE);
      rpb = usable_side(cfg_reg[CSR_ROWS_PER_BURST], SIDE_MAX);
      sx = raster_col * bw / sw;
      if (sx >= bw) begin
         sx = bw - 1;
      end
      sy = raster_row * bh / sh;
      if (sy >= bh) begin
         sy = bh - 1;
      end
      addr = (sy * bw + sx) % BUFFER_DEPTH;
      last_col = (raster_col + 1) >= sw;
      last_row = (raster_row + 1) >= sh;
      b.pixel     = frame_store[addr];
      b.frame_end = last_col && last_row;
      b.burst_end = last_col && (last_row || (burst_row + 1) >= rpb);
      if (b.frame_end) begin
         raster_col = 0;
         raster_row = 0;
         burst_row  = 0;
      end else if (last_col) begin
         raster_col = 0;
         raster_row = (raster_row + 1) & 8'hFF;
         burst_row  = b.burst_end ? 0 : ((burst_row + 1) & 8'hFF);
      end else begin
         raster_col = (raster_col + 1) & 8'hFF;
      end
      return b;
   endfunction

   always @(posedge clock) begin : watch
      screen_beat_type want;
      if (reset) begin
         raster_col = 0;
         raster_row = 0;
         burst_row  = 0;
         cfg_reg[CSR_BUFFER_WIDTH]   = RST_BUFFER_WIDTH;
         cfg_reg[CSR_BUFFER_HEIGHT]  = RST_BUFFER_HEIGHT;
         cfg_reg[CSR_SCREEN_WIDTH]   = RST_SCREEN_WIDTH;
         cfg_reg[CSR_SCREEN_HEIGHT]  = RST_SCREEN_HEIGHT;
         cfg_reg[CSR_ROWS_PER_BURST] = RST_ROWS_PER_BURST;
         pending_pixels.delete();
      end else begin
         if (csr_write_enable && csr_index <= CSR_ROWS_PER_BURST) begin
            cfg_reg[csr_index] = csr_write_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               $error("pixel beat with nothing expected: pixel %h", rsp_pixel);
               errors++;
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_pixel !== want.pixel) begin
                  $error("pixel: expected %h, got %h", want.pixel, rsp_pixel);
                  errors++;
               end
               if (rsp_burst_end !== want.burst_end) begin
                  $error("burst_end: expected %b, got %b", want.burst_end, rsp_burst_end);
                  errors++;
               end
               if (rsp_frame_end !== want.frame_end) begin
                  $error("frame_end: expected %b, got %b", want.frame_end, rsp_frame_end);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_operation == OP_WRITE) begin
               if (req_pixel_address < BUFFER_DEPTH) begin
                  frame_store[req_pixel_address] = req_pixel_value;
               end
            end else begin
               pending_pixels.push_back(predict_screen_pixel());
            end
         end
      end
      outstanding    <= pending_pixels.size();
      mismatch_count <= errors;
   end

endmodule

FILE: tb/nearest_neighbor_frame_scaler_top_tb.sv
module nearest_neighbor_frame_scaler_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import nnfs_pkg::*;

   localparam int DEPTH         = 16384;
   localparam int SCREEN_MAX    = 256;
   // longest run of cycles with no beat, csr write or reset before giving up
   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_CYCLES  = 60;
   localparam int LONG_HOLD     = 400;
   // index outside the register file, must be ignored
   localparam logic [CSR_I_W-1:0] CSR_SPARE = 3'd7;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic               clock;
   logic               reset;
   logic               csr_write_enable;
   logic [CSR_I_W-1:0] csr_index;
   logic [CFG_W-1:0]   csr_write_data;
   logic               req_valid;
   logic               req_stall;
   logic               req_operation;
   logic [ADDR_W-1:0]  req_pixel_address;
   logic [PIX_W-1:0]   req_pixel_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [PIX_W-1:0]   rsp_pixel;
   logic               rsp_burst_end;
   logic               rsp_frame_end;
   int                 outstanding;
   int                 mismatch_count;

   // stimulus-side knobs and bookkeeping
   int                 sender_idle_pct = 0;
   int                 rsp_stall_pct   = 0;
   bit                 hold_off_pending = 1'b0;
   bit                 stored [DEPTH];
   int unsigned        readable [$];
   logic [CFG_W-1:0]   cfg_now [0:CSR_ROWS_PER_BURST];

   nearest_neighbor_frame_scaler_top #(
      .BUFFER_DEPTH(DEPTH),
      .MAX_SCREEN_SIDE(SCREEN_MAX)
   ) u_top (.*);

   scaled_pixel_checker #(
      .BUFFER_DEPTH(DEPTH),
      .MAX_SCREEN_SIDE(SCREEN_MAX)
   ) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stall, or one long hold-off when asked for
   initial begin : receiver
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending <= 1'b0;
            // keep the output blocked so the pixel pipe backs up into req
            for (n = 0; n < LONG_HOLD; n++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // watchdog: any beat, csr write or reset counts as progress
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             csr_write_enable || reset) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // same saturation the block applies, used to know which entries get read
   function automatic int unsigned side_of(input logic [CFG_W-1:0] v,
                                           input int unsigned ceiling);
      int unsigned s;
      s = v;
      if (s == 0) begin
         s = 1;
      end else if (s > ceiling) begin
         s = ceiling;
      end
      return s;
   endfunction

   // mostly small sides, now and then zero or a large value
   function automatic logic [CFG_W-1:0] pick_side();
      logic [CFG_W-1:0] v;
      if ($urandom_range(99) < 85) begin
         v = CFG_W'($urandom_range(1, 12));
      end else begin
         case ($urandom_range(4))
            0: v = 9'd0;
            1: v = 9'd255;
            2: v = 9'd256;
            3: v = 9'd257;
            default: v = 9'd511;
         endcase
      end
      return v;
   endfunction

   function automatic logic [CFG_W-1:0] pick_burst();
      logic [CFG_W-1:0] v;
      if ($urandom_range(99) < 80) begin
         v = CFG_W'($urandom_range(0, 6));
      end else begin
         case ($urandom_range(2))
            0: v = 9'd256;
            1: v = 9'd300;
            default: v = 9'd511;
         endcase
      end
      return v;
   endfunction

   // one req beat, with random idle cycles ahead of it
   task automatic send_beat(input logic op, input logic [ADDR_W-1:0] addr,
                            input logic [PIX_W-1:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_pixel_address <= addr;
      req_pixel_value   <= value;
      if (op == OP_WRITE) begin
         stored[addr] = 1'b1;
      end
      do @(posedge clock); while (req_stall);
   endtask

   task automatic emit_pixel();
      send_beat(OP_EMIT, ADDR_W'($urandom), PIX_W'($urandom));
   endtask

   // enable stays high across back-to-back writes, the caller lowers it
   task automatic set_register(input logic [CSR_I_W-1:0] idx,
                               input logic [CFG_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      if (idx <= CSR_ROWS_PER_BURST) begin
         cfg_now[idx] = value;
      end
      @(posedge clock);
   endtask

   task automatic configure(input logic [CFG_W-1:0] bw, bh, sw, sh, rpb);
      set_register(CSR_BUFFER_WIDTH, bw);
      set_register(CSR_BUFFER_HEIGHT, bh);
      set_register(CSR_SCREEN_WIDTH, sw);
      set_register(CSR_SCREEN_HEIGHT, sh);
      set_register(CSR_ROWS_PER_BURST, rpb);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            sender_idle_pct = 0;
            rsp_stall_pct   = 0;
         end
         IDLE_SENDER: begin
            sender_idle_pct = 72;
            rsp_stall_pct   = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct = 0;
            rsp_stall_pct   = 72;
         end
         default: begin
            sender_idle_pct = 30;
            rsp_stall_pct   = 30;
         end
      endcase
   endtask

   // every entry any raster position up to (col_hi, row_hi) can read under the
   // current setting is written unless stored, so no emit ever reads an unwritten entry;
   // positions left over from an earlier setting are covered by the full range
   task automatic fill_readable(input int col_hi, input int row_hi);
      int unsigned bw, bh, sw, sh, sx, sy, a;
      int          c, r;
      bit          col_hit [256];
      bit          row_hit [256];
      bw = side_of(cfg_now[CSR_BUFFER_WIDTH], SIDE_MAX);
      bh = side_of(cfg_now[CSR_BUFFER_HEIGHT], SIDE_MAX);
      sw = side_of(cfg_now[CSR_SCREEN_WIDTH], SCREEN_MAX);
      sh = side_of(cfg_now[CSR_SCREEN_HEIGHT], SCREEN_MAX);
      for (c = 0; c <= col_hi; c++) begin
         sx = c * bw / sw;
         col_hit[(sx >= bw) ? bw - 1 : sx] = 1'b1;
      end
      for (r = 0; r <= row_hi; r++) begin
         sy = r * bh / sh;
         row_hit[(sy >= bh) ? bh - 1 : sy] = 1'b1;
      end
      readable.delete();
      for (r = 0; r < 256; r++) begin
         for (c = 0; c < 256; c++) begin
            if (row_hit[r] && col_hit[c]) begin
               a = (r * bw + c) % DEPTH;
               readable.push_back(a);
               if (!stored[a]) begin
                  send_beat(OP_WRITE, ADDR_W'(a), PIX_W'($urandom));
               end
            end
         end
      end
   endtask

   // wait for the last pixel, then for the block to finish any write in flight
   task automatic settle();
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mix of emits and writes; writes mostly hit entries the raster reads
   task automatic run_items(input int items, input int emit_pct);
      int i;
      for (i = 0; i < items; i++) begin
         if ($urandom_range(99) < 2) begin
            // sender pause until every pixel has come back
            req_valid <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
         end
         if ($urandom_range(99) < emit_pct) begin
            emit_pixel();
         end else if ($urandom_range(3) != 0) begin
            send_beat(OP_WRITE, ADDR_W'(readable[$urandom_range(readable.size() - 1)]),
                      PIX_W'($urandom));
         end else begin
            send_beat(OP_WRITE, ADDR_W'($urandom), PIX_W'($urandom));
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic run_scale_phase(input logic [CFG_W-1:0] bw, bh, sw, sh, rpb,
                                  input int items, input int emit_pct,
                                  input idle_mode_type mode);
      set_idling(mode);
      configure(bw, bh, sw, sh, rpb);
      fill_readable(255, 255);
      run_items(items, emit_pct);
      settle();
   endtask

   initial begin : stimulus
      int               k;
      logic [CFG_W-1:0] bw, bh, sw, sh;
      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_index         = CSR_BUFFER_WIDTH;
      csr_write_data    = '0;
      req_valid         = 1'b0;
      req_operation     = OP_WRITE;
      req_pixel_address = '0;
      req_pixel_value   = '0;
      cfg_now[CSR_BUFFER_WIDTH]   = RST_BUFFER_WIDTH;
      cfg_now[CSR_BUFFER_HEIGHT]  = RST_BUFFER_HEIGHT;
      cfg_now[CSR_SCREEN_WIDTH]   = RST_SCREEN_WIDTH;
      cfg_now[CSR_SCREEN_HEIGHT]  = RST_SCREEN_HEIGHT;
      cfg_now[CSR_ROWS_PER_BURST] = RST_ROWS_PER_BURST;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: only the first four pixels of row 0, entries 0 and 1
      send_beat(OP_WRITE, '1, '1);
      send_beat(OP_WRITE, '0, '0);
      send_beat(OP_WRITE, 14'd1, '1);
      fill_readable(3, 0);
      send_beat(OP_EMIT, '1, '1);
      send_beat(OP_EMIT, '0, '0);
      emit_pixel();
      emit_pixel();
      req_valid <= 1'b0;
      settle();

      // zero width and burst act as one, height 511 saturates;
      // then seven emits from where the raster stood, every row ends a burst
      set_register(CSR_SPARE, '1);
      configure(9'd0, 9'd511, 9'd3, 9'd2, 9'd0);
      fill_readable(255, 255);
      repeat (7) emit_pixel();
      req_valid <= 1'b0;
      settle();

      // 256x256 buffer on a 3x3 screen: source addresses wrap past the depth,
      // burst length 300 saturates so only the last row ends a burst
      configure(9'd256, 9'd256, 9'd3, 9'd3, 9'd300);
      fill_readable(255, 255);
      repeat (10) emit_pixel();
      req_valid <= 1'b0;
      settle();

      // leave the raster deep in a 9x9 screen, then shrink the screen so the
      // position lies past its edge
      run_scale_phase(9'd9, 9'd9, 9'd9, 9'd9, 9'd4, 50, 100, IDLE_NONE);
      run_scale_phase(9'd6, 9'd6, 9'd2, 9'd2, 9'd3, 30, 70, IDLE_BOTH);

      // long receiver hold-off with the sender pushing emits the whole time
      set_idling(IDLE_NONE);
      configure(9'd7, 9'd5, 9'd6, 9'd4, 9'd2);
      fill_readable(255, 255);
      hold_off_pending <= 1'b1;
      run_items(40, 100);
      settle();

      // widest and tallest screens, both with full frames
      run_scale_phase(9'd5, 9'd3, 9'd511, 9'd1, 9'd257, 300, 100, IDLE_NONE);
      run_scale_phase(9'd2, 9'd200, 9'd1, 9'd256, 9'd256, 300, 90, IDLE_RECEIVER);

      // random settings, idling style rotates from phase to phase
      for (k = 0; k < 8; k++) begin
         bw = pick_side();
         bh = pick_side();
         sw = pick_side();
         sh = pick_side();
         // large buffer and large screen on one axis would read too many entries
         if (side_of(bw, SIDE_MAX) > 12 && side_of(sw, SCREEN_MAX) > 12) begin
            sw = CFG_W'($urandom_range(1, 6));
         end
         if (side_of(bh, SIDE_MAX) > 12 && side_of(sh, SCREEN_MAX) > 12) begin
            sh = CFG_W'($urandom_range(1, 6));
         end
         run_scale_phase(bw, bh, sw, sh, pick_burst(), $urandom_range(50, 90),
                         $urandom_range(50, 85), idle_mode_type'(k % 4));
      end

      // everything sent; let the tail drain and catch any stray beat
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
